// File: src/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// Shared types, operation codes and character constants for the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

  localparam int ValueW  = 64;
  localparam int NDigits = 20;               // max text digits of a 64-bit value
  localparam int BcdW    = 4 * NDigits;
  localparam int RemW    = 5;                // holds 0..NDigits
  localparam int BitCntW = 6;                // indexes the 64 value bits

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_LHEX = 2'd2,
    OP_UHEX = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;  // '-'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [3:0] DIGIT_TEN    = 4'd10;

  // One digit (0..15) to its ASCII code.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < DIGIT_TEN) begin
      digit_char = CHAR_ZERO + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d - DIGIT_TEN};
    end
  endfunction

endpackage

// File: src/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 64-bit value as signed/unsigned decimal or lower/upper hex text,
// one ASCII character per beat, most significant first, no leading zeros.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  -------   -----------------------------  ---------------------------------
//  command   value[63:0], operation[1:0]    taken when start && !busy
//  result    character[7:0], last           one beat per cycle with strobe
//
//  Decimal: shift-and-add-3 binary to BCD of all 64 value bits in one shared
//  digit row, then the characters (sign, then 20 digit slots, leading zero
//  slots skipped silently). Hex skips the conversion.
//  busy is high from the accept until the cycle after the last beat.
//  rst (synchronous) returns to idle.
//  The receiver cannot stall; a beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
  import itoa_fmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ValueW-1:0] value,
  input  logic [1:0]        operation,
  output logic              busy,
  output logic              strobe,
  output logic [7:0]        character,
  output logic              last
);

  state_t              state, state_next;
  logic [ValueW-1:0]   bin, bin_next;
  logic [BcdW-1:0]     bcd, bcd_next;
  logic [BcdW-1:0]     bcd_adj;
  logic [BitCntW-1:0]  bit_cnt, bit_cnt_next;
  logic [RemW-1:0]     rem, rem_next;
  logic                lead, lead_next;
  logic                neg, neg_next;
  logic                upper, upper_next;
  logic                start_neg;
  logic [3:0]          top;
  logic                skip;

  assign start_neg = (op_t'(operation) == OP_SDEC) && value[ValueW-1];
  assign top       = bcd[BcdW-1 -: 4];
  // leading zero slot, never the final one
  assign skip      = lead && (top == 4'd0) && (rem > RemW'(1));

  // add-3 correction over every BCD digit, ahead of the shift
  always_comb begin
    for (int i = 0; i < NDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next   = state;
    bin_next     = bin;
    bcd_next     = bcd;
    bit_cnt_next = bit_cnt;
    rem_next     = rem;
    lead_next    = lead;
    neg_next     = neg;
    upper_next   = upper;
    case (state)
      ST_IDLE: begin
        if (start) begin
          neg_next     = start_neg;
          upper_next   = (op_t'(operation) == OP_UHEX);
          lead_next    = 1'b1;
          rem_next     = RemW'(NDigits);
          bit_cnt_next = '0;
          bin_next     = start_neg ? (~value) + ValueW'(1) : value;
          if (operation[1]) begin
            bcd_next   = {{(BcdW-ValueW){1'b0}}, value};
            state_next = ST_EMIT;
          end else begin
            bcd_next   = '0;
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_next     = {bcd_adj[BcdW-2:0], bin[ValueW-1]};
        bin_next     = {bin[ValueW-2:0], 1'b0};
        bit_cnt_next = bit_cnt + BitCntW'(1);
        if (bit_cnt == {BitCntW{1'b1}}) begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        bcd_next = {bcd[BcdW-5:0], 4'd0};
        rem_next = rem - RemW'(1);
        if (!skip) begin
          lead_next = 1'b0;
        end
        if (rem == RemW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      rem     <= '0;
      lead    <= 1'b0;
      neg     <= 1'b0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
      rem     <= rem_next;
      lead    <= lead_next;
      neg     <= neg_next;
    end
    bin   <= bin_next;
    bcd   <= bcd_next;
    upper <= upper_next;
  end

  assign busy      = (state != ST_IDLE);
  assign strobe    = (state == ST_SIGN) || ((state == ST_EMIT) && !skip);
  assign character = (state == ST_SIGN) ? CHAR_MINUS : digit_char(top, upper);
  assign last      = (state == ST_EMIT) && (rem == RemW'(1));

  // ---- assertions ----
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("busy still high after last beat");

  a_no_beat_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !strobe)
    else $error("beat while idle");

  a_sign_then_digits: assert property (@(posedge clk) disable iff (rst)
    state == ST_SIGN |=> state == ST_EMIT && lead)
    else $error("sign not followed by digit emission");

  a_emit_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> rem != '0)
    else $error("digit slot count underflow");

  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV && bit_cnt == {BitCntW{1'b1}} |=> state == ST_SIGN || state == ST_EMIT)
    else $error("conversion did not finish after 64 bits");

endmodule
